### sv/matrix4_transform_engine_core_assert.svh
// assertion macros shared by the transform engine rtl
// no dependencies; each macro takes a label, clock, reset, antecedent and consequent
`ifndef MATRIX4_TRANSFORM_ENGINE_CORE_ASSERT_SVH
`define MATRIX4_TRANSFORM_ENGINE_CORE_ASSERT_SVH

// overlapping implication, disabled while reset is high
`define M4TE_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> cons) \
      else $error("m4te assertion failed");

// next-cycle implication, disabled while reset is high
`define M4TE_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> cons) \
      else $error("m4te assertion failed");

`endif

### sv/m4te_pkg.sv
// types and constants for the 4x4 matrix transform engine
// no dependencies; used by the controller, datapath and top level
`default_nettype none

package m4te_pkg;

   // width of the external data fields
   localparam int FIELD_WIDTH = 32;

   // request actions
   typedef enum logic [1:0] {
      ACT_LOAD_CUR = 2'd0,
      ACT_LOAD_OP  = 2'd1,
      ACT_COMPOSE  = 2'd2,
      ACT_XFORM    = 2'd3
   } action_type;

   // controller states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_DRAIN
   } state_type;

   // commands from controller to datapath
   typedef struct packed {
      logic       load_cur;
      logic       load_op;
      logic       capture_vec;
      logic       issue;
      logic       compose;
      logic [1:0] row;
      logic [1:0] col;
   } cmd_type;

endpackage

`default_nettype wire

### sv/m4te_ctrl.sv
// controller state machine of the transform engine: accepts requests and sequences steps
// depends on m4te_pkg
`default_nettype none

module m4te_ctrl (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   input  wire logic [1:0]            req_action,
   output logic                       busy,
   output m4te_pkg::cmd_type          cmd
);
   import m4te_pkg::*;

   state_type  state_ff, state_in;
   logic [3:0] step_ff, step_in;
   logic       compose_ff, compose_in;
   logic       accept;
   logic       last_step;
   action_type action;

   assign action    = action_type'(req_action);
   assign accept    = start && (state_ff == ST_IDLE);
   assign last_step = compose_ff ? (step_ff == 4'd15) : (step_ff == 4'd3);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start && (action == ACT_COMPOSE || action == ACT_XFORM)) begin
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            if (last_step) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // step counter and mode
   always_comb begin
      step_in    = step_ff;
      compose_in = compose_ff;
      if (accept) begin
         step_in    = 4'd0;
         compose_in = (action == ACT_COMPOSE);
      end else if (state_ff == ST_RUN) begin
         step_in = step_ff + 4'd1;
      end
   end

   // outputs
   always_comb begin
      cmd             = '0;
      cmd.compose     = compose_ff;
      cmd.row         = compose_ff ? step_ff[3:2] : step_ff[1:0];
      cmd.col         = step_ff[1:0];
      busy            = 1'b1;
      unique case (state_ff)
         ST_IDLE: begin
            busy = 1'b0;
            if (start) begin
               unique case (action)
                  ACT_LOAD_CUR: cmd.load_cur    = 1'b1;
                  ACT_LOAD_OP:  cmd.load_op     = 1'b1;
                  ACT_XFORM:    cmd.capture_vec = 1'b1;
                  ACT_COMPOSE:  cmd.load_cur    = 1'b0;
                  default:      cmd.load_cur    = 1'b0;
               endcase
            end
         end
         ST_RUN: begin
            cmd.issue = 1'b1;
         end
         ST_DRAIN: begin
            cmd.issue = 1'b0;
         end
         default: begin
            busy = 1'b1;
         end
      endcase
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         step_ff    <= 4'd0;
         compose_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         step_ff    <= step_in;
         compose_ff <= compose_in;
      end
   end

endmodule

`default_nettype wire

### sv/m4te_datapath.sv
// datapath of the transform engine: matrix storage, four multipliers, adder and saturation
// depends on m4te_pkg; driven by commands from m4te_ctrl
`default_nettype none

module m4te_datapath #(
   parameter int DATA_WIDTH = 32,
   parameter int FRAC_BITS  = 16
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire m4te_pkg::cmd_type                   cmd,
   input  wire logic [3:0]                          req_elem_index,
   input  wire logic signed [m4te_pkg::FIELD_WIDTH-1:0] req_elem_value,
   input  wire logic signed [m4te_pkg::FIELD_WIDTH-1:0] req_in_x,
   input  wire logic signed [m4te_pkg::FIELD_WIDTH-1:0] req_in_y,
   input  wire logic signed [m4te_pkg::FIELD_WIDTH-1:0] req_in_z,
   input  wire logic signed [m4te_pkg::FIELD_WIDTH-1:0] req_in_w,
   output logic                                     rsp_valid,
   output logic signed [m4te_pkg::FIELD_WIDTH-1:0]  rsp_out_x,
   output logic signed [m4te_pkg::FIELD_WIDTH-1:0]  rsp_out_y,
   output logic signed [m4te_pkg::FIELD_WIDTH-1:0]  rsp_out_z,
   output logic signed [m4te_pkg::FIELD_WIDTH-1:0]  rsp_out_w,
   output logic                                     rsp_saturated
);
   import m4te_pkg::*;

   localparam int DW = DATA_WIDTH;
   localparam int FW = 2 * DATA_WIDTH;                // full product width
   localparam int QW = 2 * DATA_WIDTH - FRAC_BITS;    // bits kept from a product
   localparam int PW = (QW > DW) ? QW : DW;           // shifted product width
   localparam int SW = PW + 2;                       // four-term sum width
   localparam int CW = DATA_WIDTH + FIELD_WIDTH;     // input clamp compare width

   localparam logic [DW-1:0] ELEM_MAX = {1'b0, {(DW-1){1'b1}}};
   localparam logic [DW-1:0] ELEM_MIN = {1'b1, {(DW-1){1'b0}}};
   localparam logic [DW-1:0] ELEM_ONE = (FRAC_BITS <= DW - 2) ?
                                        ({{(DW-1){1'b0}}, 1'b1} << FRAC_BITS) : ELEM_MAX;
   localparam logic signed [CW-1:0] IN_MAX = CW'(ELEM_MAX);
   localparam logic signed [CW-1:0] IN_MIN = -IN_MAX - CW'(1);

   // cur_ff[col][row] and op_ff[row][col]: each inner array is read at one address
   logic signed [DW-1:0] cur_ff [4][4];
   logic signed [DW-1:0] op_ff  [4][4];
   logic signed [DW-1:0] vec_ff [4];
   logic signed [DW-1:0] rowbuf_ff [3];

   logic signed [PW-1:0]   prod_ff [4];
   logic signed [PW-1:0]   prod_in [4];
   logic signed [FW-1:0]   full_prod [4];
   logic signed [DW-1:0]   mul_a [4];
   logic signed [DW-1:0]   mul_b [4];

   logic       s2_valid_ff;
   logic       s2_compose_ff;
   logic [1:0] s2_row_ff;
   logic [1:0] s2_col_ff;

   logic signed [SW-1:0] sum;
   logic signed [DW-1:0] res;
   logic                 clip;
   logic                 upper_ones;
   logic                 upper_zeros;

   logic signed [FIELD_WIDTH-1:0] comp_ff [4];
   logic                          sat_ff;
   logic                          valid_ff;

   // saturate a 32-bit input to the element range
   function automatic logic [DW-1:0] clamp_in(input logic signed [FIELD_WIDTH-1:0] v);
      logic signed [CW-1:0] wide;
      wide = CW'(v);
      if (wide > IN_MAX) begin
         return ELEM_MAX;
      end else if (wide < IN_MIN) begin
         return ELEM_MIN;
      end
      return DW'(v);
   endfunction

   // operand selection and the four multipliers
   always_comb begin
      for (int k = 0; k < 4; k++) begin
         mul_a[k]     = cur_ff[k][cmd.row];
         mul_b[k]     = cmd.compose ? op_ff[k][cmd.col] : vec_ff[k];
         full_prod[k] = FW'(mul_a[k]) * FW'(mul_b[k]);
         prod_in[k]   = PW'($signed(full_prod[k][FW-1:FRAC_BITS]));
      end
   end

   // sum of the four products and saturation
   always_comb begin
      sum         = SW'(prod_ff[0]) + SW'(prod_ff[1]) + SW'(prod_ff[2]) + SW'(prod_ff[3]);
      upper_ones  = &sum[SW-1:DW-1];
      upper_zeros = ~|sum[SW-1:DW-1];
      clip        = !(upper_ones || upper_zeros);
      if (clip) begin
         res = sum[SW-1] ? ELEM_MIN : ELEM_MAX;
      end else begin
         res = sum[DW-1:0];
      end
   end

   // product stage and its tag
   always_ff @(posedge clock) begin
      if (cmd.issue) begin
         for (int k = 0; k < 4; k++) begin
            prod_ff[k] <= prod_in[k];
         end
      end
      s2_compose_ff <= cmd.compose;
      s2_row_ff     <= cmd.row;
      s2_col_ff     <= cmd.col;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
         valid_ff    <= 1'b0;
      end else begin
         s2_valid_ff <= cmd.issue;
         valid_ff    <= s2_valid_ff && !s2_compose_ff && (s2_row_ff == 2'd3);
      end
   end

   // vertex capture
   always_ff @(posedge clock) begin
      if (cmd.capture_vec) begin
         vec_ff[0] <= clamp_in(req_in_x);
         vec_ff[1] <= clamp_in(req_in_y);
         vec_ff[2] <= clamp_in(req_in_z);
         vec_ff[3] <= clamp_in(req_in_w);
      end
   end

   // current matrix: element loads and row write-back of compose
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
               cur_ff[c][r] <= (c == r) ? ELEM_ONE : '0;
            end
         end
      end else if (cmd.load_cur) begin
         cur_ff[req_elem_index[3:2]][req_elem_index[1:0]] <= clamp_in(req_elem_value);
      end else if (s2_valid_ff && s2_compose_ff && (s2_col_ff == 2'd3)) begin
         for (int c = 0; c < 3; c++) begin
            cur_ff[c][s2_row_ff] <= rowbuf_ff[c];
         end
         cur_ff[3][s2_row_ff] <= res;
      end
   end

   // row buffer holds the first three results of a compose row
   always_ff @(posedge clock) begin
      if (s2_valid_ff && s2_compose_ff && (s2_col_ff != 2'd3)) begin
         rowbuf_ff[s2_col_ff] <= res;
      end
   end

   // operand matrix loads
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int r = 0; r < 4; r++) begin
            for (int c = 0; c < 4; c++) begin
               op_ff[r][c] <= (c == r) ? ELEM_ONE : '0;
            end
         end
      end else if (cmd.load_op) begin
         op_ff[req_elem_index[1:0]][req_elem_index[3:2]] <= clamp_in(req_elem_value);
      end
   end

   // transform result registers
   always_ff @(posedge clock) begin
      if (s2_valid_ff && !s2_compose_ff) begin
         comp_ff[s2_row_ff] <= FIELD_WIDTH'(res);
         if (s2_row_ff == 2'd0) begin
            sat_ff <= clip;
         end else begin
            sat_ff <= sat_ff | clip;
         end
      end
   end

   assign rsp_valid     = valid_ff;
   assign rsp_out_x     = comp_ff[0];
   assign rsp_out_y     = comp_ff[1];
   assign rsp_out_z     = comp_ff[2];
   assign rsp_out_w     = comp_ff[3];
   assign rsp_saturated = sat_ff;

endmodule

`default_nettype wire

### sv/matrix4_transform_engine_core.sv
// Loads: busy stays low, a load may follow in the next cycle.
// Transform: one matrix row per cycle goes through four multipliers into the product registers,
// then its saturated sum into the result registers; a new request waits for the result strobe.
// Compose: busy after the start transfer for sixteen row-column steps plus drain.
// Synchronous reset sets both matrices to identity and returns the controller to idle.
`default_nettype none
`include "matrix4_transform_engine_core_assert.svh"

module matrix4_transform_engine_core #(
   parameter int DATA_WIDTH = 32,
   parameter int FRAC_BITS  = 16
) (
   input  wire logic                                    clock,
   input  wire logic                                    reset,
   input  wire logic                                    start,
   output logic                                         busy,
   input  wire logic [1:0]                              req_action,
   input  wire logic [3:0]                              req_elem_index,
   input  wire logic signed [m4te_pkg::FIELD_WIDTH-1:0] req_elem_value,
   input  wire logic signed [m4te_pkg::FIELD_WIDTH-1:0] req_in_x,
   input  wire logic signed [m4te_pkg::FIELD_WIDTH-1:0] req_in_y,
   input  wire logic signed [m4te_pkg::FIELD_WIDTH-1:0] req_in_z,
   input  wire logic signed [m4te_pkg::FIELD_WIDTH-1:0] req_in_w,
   output logic                                         rsp_valid,
   output logic signed [m4te_pkg::FIELD_WIDTH-1:0]      rsp_out_x,
   output logic signed [m4te_pkg::FIELD_WIDTH-1:0]      rsp_out_y,
   output logic signed [m4te_pkg::FIELD_WIDTH-1:0]      rsp_out_z,
   output logic signed [m4te_pkg::FIELD_WIDTH-1:0]      rsp_out_w,
   output logic                                         rsp_saturated
);
   import m4te_pkg::*;

   cmd_type cmd;

   // sequencing
   m4te_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .req_action (req_action),
      .busy       (busy),
      .cmd        (cmd)
   );

   // storage and arithmetic
   m4te_datapath #(
      .DATA_WIDTH (DATA_WIDTH),
      .FRAC_BITS  (FRAC_BITS)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .req_elem_index (req_elem_index),
      .req_elem_value (req_elem_value),
      .req_in_x       (req_in_x),
      .req_in_y       (req_in_y),
      .req_in_z       (req_in_z),
      .req_in_w       (req_in_w),
      .rsp_valid      (rsp_valid),
      .rsp_out_x      (rsp_out_x),
      .rsp_out_y      (rsp_out_y),
      .rsp_out_z      (rsp_out_z),
      .rsp_out_w      (rsp_out_w),
      .rsp_saturated  (rsp_saturated)
   );

   // a transform transfer is followed by its result strobe
   `M4TE_ASSERT_IMP(a_xform_latency, clock, reset,
      start && !busy && (req_action == ACT_XFORM), ##6 rsp_valid)

   // compose keeps the block busy and then returns it to idle
   `M4TE_ASSERT_IMP(a_compose_busy, clock, reset,
      start && !busy && (req_action == ACT_COMPOSE), ##17 busy ##1 !busy)

   // loads never make the block busy
   `M4TE_ASSERT_NXT(a_load_idle, clock, reset,
      start && !busy && (req_action == ACT_LOAD_CUR || req_action == ACT_LOAD_OP), !busy)

endmodule

`default_nettype wire

### sim/matrix4_transform_engine_core_tb.sv
// self-checking testbench for the 4x4 matrix transform engine core
// depends on m4te_pkg and matrix4_transform_engine_core; predicts every vertex result in q16.16
`default_nettype none

module matrix4_transform_engine_core_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import m4te_pkg::*;

   localparam int FRAC_BITS    = 16;
   localparam int STALL_LIMIT  = 1000;
   localparam int END_SETTLE   = 40;
   localparam int MAX_REPORTS  = 60;
   localparam int RANDOM_ITEMS = 1400;
   localparam int FINAL_ITEMS  = 250;

   typedef logic signed [FIELD_WIDTH-1:0] fixed_type;

   typedef struct {
      fixed_type x;
      fixed_type y;
      fixed_type z;
      fixed_type w;
      logic      sat;
   } vertex_result_type;

   localparam fixed_type FIX_MAX = {1'b0, {(FIELD_WIDTH-1){1'b1}}};
   localparam fixed_type FIX_MIN = {1'b1, {(FIELD_WIDTH-1){1'b0}}};
   localparam fixed_type FIX_ONE = fixed_type'(1) <<< FRAC_BITS;
   localparam longint SUM_MAX = longint'(FIX_MAX);
   localparam longint SUM_MIN = longint'(FIX_MIN);

   // dut connections, all inputs driven from time zero
   logic      clock          = 1'b0;
   logic      reset          = 1'b1;
   logic      start          = 1'b0;
   logic      busy;
   logic      [1:0] req_action     = ACT_LOAD_CUR;
   logic      [3:0] req_elem_index = '0;
   fixed_type req_elem_value = '0;
   fixed_type req_in_x       = '0;
   fixed_type req_in_y       = '0;
   fixed_type req_in_z       = '0;
   fixed_type req_in_w       = '0;
   logic      rsp_valid;
   fixed_type rsp_out_x;
   fixed_type rsp_out_y;
   fixed_type rsp_out_z;
   fixed_type rsp_out_w;
   logic      rsp_saturated;

   // shadow copy of the engine state and pending vertex results
   fixed_type         cur_mat [16];
   fixed_type         opr_mat [16];
   vertex_result_type expected_vertices [$];

   int error_count  = 0;
   int items_sent   = 0;
   int stall_cycles = 0;
   bit idling_on    = 1'b1;

   always #4 clock = ~clock;

   matrix4_transform_engine_core #(
      .DATA_WIDTH(FIELD_WIDTH),
      .FRAC_BITS (FRAC_BITS)
   ) i_dut (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_action    (req_action),
      .req_elem_index(req_elem_index),
      .req_elem_value(req_elem_value),
      .req_in_x      (req_in_x),
      .req_in_y      (req_in_y),
      .req_in_z      (req_in_z),
      .req_in_w      (req_in_w),
      .rsp_valid     (rsp_valid),
      .rsp_out_x     (rsp_out_x),
      .rsp_out_y     (rsp_out_y),
      .rsp_out_z     (rsp_out_z),
      .rsp_out_w     (rsp_out_w),
      .rsp_saturated (rsp_saturated)
   );

   // clip an exact sum to the element range
   function automatic fixed_type clip_to_range(longint sum, inout logic clipped);
      if (sum > SUM_MAX) begin
         clipped = 1'b1;
         return FIX_MAX;
      end
      if (sum < SUM_MIN) begin
         clipped = 1'b1;
         return FIX_MIN;
      end
      return fixed_type'(sum);
   endfunction

   // one row of the current matrix times a column vector, products floored
   function automatic fixed_type row_dot(int row, fixed_type vec [4], inout logic clipped);
      longint acc;
      acc = 0;
      for (int k = 0; k < 4; k++)
         acc += (longint'(cur_mat[k*4+row]) * longint'(vec[k])) >>> FRAC_BITS;
      return clip_to_range(acc, clipped);
   endfunction

   // update the shadow state for one accepted request
   function automatic void model_request(action_type act, logic [3:0] idx, fixed_type val,
                                         fixed_type vx, fixed_type vy, fixed_type vz,
                                         fixed_type vw);
      fixed_type         next_mat [16];
      fixed_type         vec [4];
      vertex_result_type res;
      logic              clipped;
      case (act)
         ACT_LOAD_CUR: cur_mat[idx] = val;
         ACT_LOAD_OP:  opr_mat[idx] = val;
         ACT_COMPOSE: begin
            // clipping in compose is silent
            clipped = 1'b0;
            for (int j = 0; j < 4; j++) begin
               vec = '{opr_mat[j*4], opr_mat[j*4+1], opr_mat[j*4+2], opr_mat[j*4+3]};
               for (int i = 0; i < 4; i++)
                  next_mat[j*4+i] = row_dot(i, vec, clipped);
            end
            cur_mat = next_mat;
         end
         default: begin
            vec = '{vx, vy, vz, vw};
            clipped = 1'b0;
            res.x = row_dot(0, vec, clipped);
            res.y = row_dot(1, vec, clipped);
            res.z = row_dot(2, vec, clipped);
            res.w = row_dot(3, vec, clipped);
            res.sat = clipped;
            expected_vertices.push_back(res);
         end
      endcase
   endfunction

   // small q16.16 value within +/-2.0
   function automatic fixed_type rand_small();
      return fixed_type'(int'($urandom_range(0, 262144)) - 131072);
   endfunction

   // value mix: extremes, zero, unity, small and full-range words
   function automatic fixed_type rand_fixed();
      case ($urandom_range(0, 9))
         0:       return FIX_MAX;
         1:       return FIX_MIN;
         2:       return '0;
         3:       return $urandom_range(0, 1) ? FIX_ONE : -FIX_ONE;
         4, 5, 6: return rand_small();
         default: return fixed_type'($urandom);
      endcase
   endfunction

   task automatic hold_start_low(int cycles);
      repeat (cycles) begin
         @(negedge clock);
         start <= 1'b0;
      end
   endtask

   // drive one request and wait for its transfer
   task automatic send_request(action_type act, logic [3:0] idx, fixed_type val,
                               fixed_type vx, fixed_type vy, fixed_type vz, fixed_type vw);
      @(negedge clock);
      start          <= 1'b1;
      req_action     <= act;
      req_elem_index <= idx;
      req_elem_value <= val;
      req_in_x       <= vx;
      req_in_y       <= vy;
      req_in_z       <= vz;
      req_in_w       <= vw;
      do @(posedge clock); while (busy);
      model_request(act, idx, val, vx, vy, vz, vw);
      items_sent++;
      if (idling_on && $urandom_range(0, 3) == 0)
         hold_start_low($urandom_range(1, 7));
   endtask

   // request wrappers, unused fields carry random noise
   task automatic load_current(logic [3:0] idx, fixed_type val);
      send_request(ACT_LOAD_CUR, idx, val, fixed_type'($urandom), fixed_type'($urandom),
                   fixed_type'($urandom), fixed_type'($urandom));
   endtask

   task automatic load_operand(logic [3:0] idx, fixed_type val);
      send_request(ACT_LOAD_OP, idx, val, fixed_type'($urandom), fixed_type'($urandom),
                   fixed_type'($urandom), fixed_type'($urandom));
   endtask

   task automatic compose_matrices();
      send_request(ACT_COMPOSE, 4'($urandom), fixed_type'($urandom), fixed_type'($urandom),
                   fixed_type'($urandom), fixed_type'($urandom), fixed_type'($urandom));
   endtask

   task automatic transform(fixed_type vx, fixed_type vy, fixed_type vz, fixed_type vw);
      send_request(ACT_XFORM, 4'($urandom), fixed_type'($urandom), vx, vy, vz, vw);
   endtask

   // sender holds off until every vertex result is back
   task automatic wait_results_drained();
      @(negedge clock);
      start <= 1'b0;
      while (expected_vertices.size() != 0)
         @(posedge clock);
   endtask

   // identity matrix passes extreme vertex components unchanged
   task automatic test_identity_transform();
      transform(FIX_MAX, FIX_MIN, '0, FIX_ONE);
      transform(-fixed_type'(1), fixed_type'(1), FIX_MIN, FIX_MAX);
   endtask

   // extreme elements at the first and last index, with and without clipping
   task automatic test_element_extremes();
      load_current(4'd0, FIX_MAX);
      load_current(4'd15, FIX_MIN);
      load_operand(4'd0, FIX_MIN);
      load_operand(4'd15, FIX_MAX);
      transform(FIX_MAX, FIX_MAX, FIX_MAX, FIX_MAX);
      transform(FIX_ONE, '0, '0, FIX_ONE);
      wait_results_drained();
   endtask

   // products round toward minus infinity
   task automatic test_product_rounding();
      load_current(4'd0, -fixed_type'(1));
      transform(fixed_type'(1), '0, '0, '0);
      transform(-fixed_type'(1), '0, '0, '0);
      load_current(4'd0, FIX_ONE);
   endtask

   // compose with a translation, then a compose that clips silently
   task automatic test_compose();
      load_current(4'd15, FIX_ONE);
      load_operand(4'd0, FIX_ONE);
      load_operand(4'd15, FIX_ONE);
      load_operand(4'd12, fixed_type'(196608));
      compose_matrices();
      transform(fixed_type'(131072), '0, '0, FIX_ONE);
      load_current(4'd5, FIX_MAX);
      load_operand(4'd5, FIX_MAX);
      compose_matrices();
      transform('0, FIX_ONE, '0, '0);
      wait_results_drained();
   endtask

   // mostly well-formed load/compose/transform sequences with random content
   task automatic test_random_sequences(int target);
      int goal;
      int kind;
      goal = items_sent + target;
      while (items_sent < goal) begin
         kind = $urandom_range(0, 19);
         if (kind < 9) begin
            repeat ($urandom_range(1, 6)) begin
               if ($urandom_range(0, 1))
                  load_current(4'($urandom), rand_fixed());
               else
                  load_operand(4'($urandom), rand_fixed());
            end
            repeat ($urandom_range(1, 3))
               transform(rand_fixed(), rand_fixed(), rand_fixed(), rand_fixed());
         end else if (kind < 13) begin
            repeat ($urandom_range(1, 4))
               load_operand(4'($urandom), rand_small());
            compose_matrices();
            transform(rand_fixed(), rand_fixed(), rand_fixed(), rand_fixed());
         end else if (kind == 13) begin
            // full reload of the current matrix pulls it back from saturation
            for (int i = 0; i < 16; i++)
               load_current(4'(i), (i % 5 == 0) ? FIX_ONE : rand_small());
         end else if (kind == 14) begin
            for (int i = 0; i < 16; i++)
               load_operand(4'(i), rand_small());
         end else begin
            // single noise request of any action
            send_request(action_type'($urandom_range(0, 3)), 4'($urandom),
                         fixed_type'($urandom), fixed_type'($urandom), fixed_type'($urandom),
                         fixed_type'($urandom), fixed_type'($urandom));
         end
         if (idling_on && $urandom_range(0, 39) == 0)
            wait_results_drained();
      end
   endtask

   // last stretch with the sender never idle
   task automatic test_back_to_back(int target);
      idling_on = 1'b0;
      test_random_sequences(target);
   endtask

   function automatic void check_field(string name, logic [FIELD_WIDTH-1:0] exp_v,
                                       logic [FIELD_WIDTH-1:0] act_v);
      if (act_v !== exp_v) begin
         error_count++;
         if (error_count <= MAX_REPORTS)
            $display("%0t: %s mismatch: expected %h, actual %h", $time, name, exp_v, act_v);
      end
   endfunction

   // compare each result transfer with the oldest prediction
   always @(posedge clock) begin : result_check
      vertex_result_type exp_r;
      if (!reset && rsp_valid) begin
         if (expected_vertices.size() == 0) begin
            error_count++;
            if (error_count <= MAX_REPORTS)
               $display("%0t: unexpected result: expected none, actual %h %h %h %h %b",
                        $time, rsp_out_x, rsp_out_y, rsp_out_z, rsp_out_w, rsp_saturated);
         end else begin
            exp_r = expected_vertices.pop_front();
            check_field("out_x", exp_r.x, rsp_out_x);
            check_field("out_y", exp_r.y, rsp_out_y);
            check_field("out_z", exp_r.z, rsp_out_z);
            check_field("out_w", exp_r.w, rsp_out_w);
            check_field("saturated", FIELD_WIDTH'(exp_r.sat), FIELD_WIDTH'(rsp_saturated));
         end
      end
   end

   // watchdog on cycles without any transfer
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) begin
         stall_cycles = 0;
      end else begin
         stall_cycles++;
         if (stall_cycles >= STALL_LIMIT) begin
            $display("** matrix4_transform_engine_core: FAILED **");
            $finish;
         end
      end
   end

   initial begin
      for (int i = 0; i < 16; i++) begin
         cur_mat[i] = (i % 5 == 0) ? FIX_ONE : '0;
         opr_mat[i] = (i % 5 == 0) ? FIX_ONE : '0;
      end
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_identity_transform();
      test_element_extremes();
      test_product_rounding();
      test_compose();
      test_random_sequences(RANDOM_ITEMS);
      test_back_to_back(FINAL_ITEMS);

      // drain, then give any stray strobe time to show up
      wait_results_drained();
      repeat (END_SETTLE) @(posedge clock);
      if (error_count == 0)
         $display("** matrix4_transform_engine_core: PASSED **");
      else
         $display("** matrix4_transform_engine_core: FAILED **");
      $finish;
   end

endmodule

`default_nettype wire
